// ----- rtl/assert_macros.svh -----
// Assertion macros for the tagged SLIP frame encoder.
// Requires clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition implies another in the same cycle
`define TSFE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("same-cycle implication violated");

// check that a condition implies another in the next cycle
`define TSFE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

// ----- rtl/tsfe_pkg.sv -----
// Package for the tagged SLIP frame encoder: line codes, register indexes
// and the run structure passed from encoder to serializer. No dependencies.
`timescale 1ns / 1ps

package tsfe_pkg;

  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  localparam logic [15:0] MIN_ROOM     = 16'd6;
  localparam logic [15:0] ROOM_RESET   = 16'd1024;
  localparam logic [16:0] CLOSE_MARGIN = 17'd3;
  localparam logic [15:0] OPEN_COUNT   = 16'd3;

  localparam int unsigned RUN_MAX = 6;

  localparam logic REG_FRAME_TAG  = 1'b0;
  localparam logic REG_FRAME_ROOM = 1'b1;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              last_idx;
    logic                    closes;
  } run_t;

endpackage

// ----- rtl/tagged_slip_frame_encoder_top.sv -----
// Path: an input transaction is registered in the input stage, then in the
// serializer's run register. Each payload byte becomes a run of up to 6 line
// bytes on the single byte output port; a new run loads as a run's last byte is sent.
// Reset: asynchronous, active low; clears frame state, tag to 0, room to 1024.
// Top level of the tagged SLIP frame encoder; uses tsfe_pkg, tsfe_encode,
// tsfe_serializer and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tagged_slip_frame_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        no_more_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  line_byte_o,
  output logic        closes_frame_o,
  output logic        last_of_run_o
);

  logic [15:0]    frame_tag_q, frame_room_q;
  logic           inq_valid_q;
  logic [7:0]     inq_byte_q;
  logic           inq_last_q;
  logic           run_ready, take, cfg_wr;
  tsfe_pkg::run_t run;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      tsfe_pkg::REG_FRAME_TAG:  prdata = {16'd0, frame_tag_q};
      tsfe_pkg::REG_FRAME_ROOM: prdata = {16'd0, frame_room_q};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_tag_q  <= '0;
      frame_room_q <= tsfe_pkg::ROOM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tsfe_pkg::REG_FRAME_TAG:  frame_tag_q  <= pwdata[15:0];
        tsfe_pkg::REG_FRAME_ROOM: frame_room_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign take       = inq_valid_q && run_ready;
  assign in_ready_o = !inq_valid_q || run_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_byte_q <= data_byte_i;
      inq_last_q <= no_more_data_i;
    end
  end

  tsfe_encode u_encode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (inq_byte_q),
    .no_more_data_i (inq_last_q),
    .take_i         (take),
    .frame_tag_i    (frame_tag_q),
    .frame_room_i   (frame_room_q),
    .run_o          (run)
  );

  tsfe_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_valid_i    (inq_valid_q),
    .run_i          (run),
    .run_ready_o    (run_ready),
    .line_byte_o    (line_byte_o),
    .closes_frame_o (closes_frame_o),
    .last_of_run_o  (last_of_run_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  `TSFE_ASSERT_IMP(a_close_is_end, out_valid_o && closes_frame_o, line_byte_o == tsfe_pkg::CODE_END)
  `TSFE_ASSERT_IMP(a_close_ends_run, out_valid_o && closes_frame_o, last_of_run_o)
  `TSFE_ASSERT_IMP(a_stall_holds_item, !in_ready_o, inq_valid_q && out_valid_o)
  `TSFE_ASSERT_NXT(a_take_fills_out, take, out_valid_o)

endmodule

// ----- rtl/tsfe_encode.sv -----
// Frame encoder: builds the line bytes for one payload byte and tracks
// the open frame and its byte count. Depends on tsfe_pkg.
`timescale 1ns / 1ps

module tsfe_encode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     data_byte_i,
  input  logic           no_more_data_i,
  input  logic           take_i,
  input  logic [15:0]    frame_tag_i,
  input  logic [15:0]    frame_room_i,
  output tsfe_pkg::run_t run_o
);

  logic        frame_open_q, frame_open_d;
  logic [15:0] bytes_written_q, bytes_written_d;
  logic [15:0] room;
  logic [15:0] base;
  logic [15:0] next_count;
  logic        is_end, is_esc, close;
  logic [2:0]  pos;

  always_comb begin
    room   = (frame_room_i < tsfe_pkg::MIN_ROOM) ? tsfe_pkg::MIN_ROOM : frame_room_i;
    is_end = (data_byte_i == tsfe_pkg::CODE_END);
    is_esc = (data_byte_i == tsfe_pkg::CODE_ESC);
    base   = frame_open_q ? bytes_written_q : tsfe_pkg::OPEN_COUNT;
    next_count = base + ((is_end || is_esc) ? 16'd2 : 16'd1);
    close  = no_more_data_i ||
             (({1'b0, next_count} + tsfe_pkg::CLOSE_MARGIN) > {1'b0, room});

    run_o.bytes = '0;
    pos         = 3'd0;
    if (!frame_open_q) begin
      run_o.bytes[0] = tsfe_pkg::CODE_END;
      run_o.bytes[1] = frame_tag_i[15:8];
      run_o.bytes[2] = frame_tag_i[7:0];
      pos            = 3'd3;
    end
    if (is_end || is_esc) begin
      run_o.bytes[pos]      = tsfe_pkg::CODE_ESC;
      run_o.bytes[pos+3'd1] = is_end ? tsfe_pkg::CODE_ESC_END : tsfe_pkg::CODE_ESC_ESC;
      pos                   = pos + 3'd2;
    end else begin
      run_o.bytes[pos] = data_byte_i;
      pos              = pos + 3'd1;
    end
    if (close) begin
      run_o.bytes[pos] = tsfe_pkg::CODE_END;
      pos              = pos + 3'd1;
    end
    run_o.last_idx = pos - 3'd1;
    run_o.closes   = close;

    frame_open_d    = !close;
    bytes_written_d = close ? 16'd0 : next_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q    <= 1'b0;
      bytes_written_q <= '0;
    end else if (take_i) begin
      frame_open_q    <= frame_open_d;
      bytes_written_q <= bytes_written_d;
    end
  end

endmodule

// ----- rtl/tsfe_serializer.sv -----
// Serializer: holds one encoded run and sends its bytes one per
// transaction on the output channel. Depends on tsfe_pkg.
`timescale 1ns / 1ps

module tsfe_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           run_valid_i,
  input  tsfe_pkg::run_t run_i,
  output logic           run_ready_o,
  output logic [7:0]     line_byte_o,
  output logic           closes_frame_o,
  output logic           last_of_run_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  tsfe_pkg::run_t run_q;
  logic           valid_q;
  logic [2:0]     idx_q;
  logic           at_last, fire, done;

  always_comb begin
    at_last        = (idx_q == run_q.last_idx);
    fire           = valid_q && out_ready_i;
    done           = fire && at_last;
    run_ready_o    = !valid_q || done;
    out_valid_o    = valid_q;
    line_byte_o    = run_q.bytes[idx_q];
    last_of_run_o  = at_last;
    closes_frame_o = at_last && run_q.closes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (run_ready_o && run_valid_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_ready_o && run_valid_i) begin
      run_q <= run_i;
    end
  end

endmodule

// ----- test/tsfe_checker.sv -----
// Checker for the tagged SLIP frame encoder: watches the register port and both
// streams, predicts every line byte and compares it with what comes out.
// Depends on tsfe_pkg for the line codes and register indexes.
`timescale 1ns / 1ps

module tsfe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        no_more_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  line_byte_i,
  input  logic        closes_frame_i,
  input  logic        last_of_run_i,
  output int          err_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] code;
    logic       closes;
    logic       last;
  } line_beat_t;

  line_beat_t  line_q[$];
  logic [15:0] tag_q;
  logic [15:0] room_q;
  logic [15:0] count_q;
  logic        open_q;
  int          errs = 0;

  function automatic void emit(input logic [7:0] code, input logic closes, input logic last);
    line_beat_t beat;
    beat.code   = code;
    beat.closes = closes;
    beat.last   = last;
    line_q.push_back(beat);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [16:0] room_eff;
    logic        esc;
    logic        closing;
    room_eff = {1'b0, (room_q < tsfe_pkg::MIN_ROOM) ? tsfe_pkg::MIN_ROOM : room_q};
    if (!open_q) begin
      emit(tsfe_pkg::CODE_END, 1'b0, 1'b0);
      emit(tag_q[15:8], 1'b0, 1'b0);
      emit(tag_q[7:0], 1'b0, 1'b0);
      count_q = tsfe_pkg::OPEN_COUNT;
      open_q  = 1'b1;
    end
    esc     = (b == tsfe_pkg::CODE_END) || (b == tsfe_pkg::CODE_ESC);
    count_q = count_q + (esc ? 16'd2 : 16'd1);
    closing = fin || (({1'b0, count_q} + tsfe_pkg::CLOSE_MARGIN) > room_eff);
    if (esc) begin
      emit(tsfe_pkg::CODE_ESC, 1'b0, 1'b0);
      emit((b == tsfe_pkg::CODE_END) ? tsfe_pkg::CODE_ESC_END : tsfe_pkg::CODE_ESC_ESC,
           1'b0, !closing);
    end else begin
      emit(b, 1'b0, !closing);
    end
    if (closing) begin
      emit(tsfe_pkg::CODE_END, 1'b1, 1'b1);
      open_q  = 1'b0;
      count_q = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_beat_t want;
    line_beat_t got;
    if (!rst_ni) begin
      tag_q   = '0;
      room_q  = tsfe_pkg::ROOM_RESET;
      count_q = '0;
      open_q  = 1'b0;
      line_q.delete();
      err_count_o <= errs;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.code   = line_byte_i;
        got.closes = closes_frame_i;
        got.last   = last_of_run_i;
        if (line_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected line byte, expected none, got %02h/%b/%b", $time,
                   got.code, got.closes, got.last);
        end else begin
          want = line_q.pop_front();
          if (got !== want) begin
            errs++;
            $display("%0t: line byte mismatch, expected %02h/%b/%b, got %02h/%b/%b",
                     $time, want.code, want.closes, want.last,
                     got.code, got.closes, got.last);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        encode_byte(data_byte_i, no_more_data_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == tsfe_pkg::REG_FRAME_TAG) begin
          tag_q = pwdata_i[15:0];
        end else begin
          room_q = pwdata_i[15:0];
        end
      end
      err_count_o <= errs;
      pending_o   <= line_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the tagged SLIP frame encoder: drives register writes and
// payload bytes with random gaps and stalls; tsfe_checker predicts and compares.
// Depends on tsfe_pkg, tsfe_checker and tagged_slip_frame_encoder_top.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        no_more_data_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  line_byte_o;
  logic        closes_frame_o;
  logic        last_of_run_o;

  int err_count;
  int pending;
  int cycle_count = 0;
  int ready_hold = 0;
  int n_items = 0;
  int n_writes = 0;
  bit burst = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tagged_slip_frame_encoder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .no_more_data_i (no_more_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_byte_o    (line_byte_o),
    .closes_frame_o (closes_frame_o),
    .last_of_run_o  (last_of_run_o)
  );

  tsfe_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .no_more_data_i (no_more_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_byte_i    (line_byte_o),
    .closes_frame_i (closes_frame_o),
    .last_of_run_i  (last_of_run_o),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  // hold ready in random stretches, mostly high, a few long stalls
  always @(posedge clk_i) begin : line_sink
    int r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready_i <= 1'b1;
        ready_hold  <= $urandom_range(0, 15);
      end else if (r < 70) begin
        out_ready_i <= 1'b1;
        ready_hold  <= $urandom_range(60, 150);
      end else if (r < 95) begin
        out_ready_i <= 1'b0;
        ready_hold  <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold  <= $urandom_range(15, 50);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0: return tsfe_pkg::CODE_END;
        1: return tsfe_pkg::CODE_ESC;
        2: return tsfe_pkg::CODE_ESC_END;
        default: return tsfe_pkg::CODE_ESC_ESC;
      endcase
    end
    if (r == 2) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_tag();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {tsfe_pkg::CODE_END, tsfe_pkg::CODE_ESC};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_room();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 5));
      1: return tsfe_pkg::MIN_ROOM;
      2: return 16'($urandom_range(7, 12));
      3: return 16'($urandom_range(13, 40));
      4: return 16'($urandom_range(41, 300));
      5: return 16'hFFFF;
      6: return 16'($urandom_range(6, 65535));
      default: return tsfe_pkg::ROOM_RESET;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    no_more_data_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
  endtask

  // drop valid and wait until every predicted line byte has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(tsfe_pkg::CODE_END, 1'b0);
    push_byte(tsfe_pkg::CODE_ESC, 1'b0);
    push_byte(tsfe_pkg::CODE_ESC_END, 1'b0);
    push_byte(tsfe_pkg::CODE_ESC_ESC, 1'b1);
    push_byte(tsfe_pkg::CODE_END, 1'b1);
    push_byte(8'h55, 1'b1);
    push_byte(8'hAA, 1'b0);
    drain();
    write_reg(tsfe_pkg::REG_FRAME_TAG, {tsfe_pkg::CODE_END, tsfe_pkg::CODE_ESC});
    write_reg(tsfe_pkg::REG_FRAME_ROOM, 16'd3);
    push_byte(8'h11, 1'b0);
    push_byte(tsfe_pkg::CODE_END, 1'b0);
    push_byte(8'h22, 1'b0);
    drain();
    write_reg(tsfe_pkg::REG_FRAME_TAG, 16'hFFFF);
    write_reg(tsfe_pkg::REG_FRAME_ROOM, 16'd7);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b0);
    push_byte(tsfe_pkg::CODE_ESC, 1'b0);
    push_byte(8'h01, 1'b0);
    drain();
    write_reg(tsfe_pkg::REG_FRAME_ROOM, 16'd0);
    push_byte(8'h02, 1'b0);
    drain();
    write_reg(tsfe_pkg::REG_FRAME_TAG, 16'h8001);
    write_reg(tsfe_pkg::REG_FRAME_ROOM, 16'hFFFF);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    drain();
    write_reg(tsfe_pkg::REG_FRAME_ROOM, tsfe_pkg::MIN_ROOM);
    push_byte(8'hFE, 1'b0);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      write_reg(tsfe_pkg::REG_FRAME_TAG, pick_tag());
      write_reg(tsfe_pkg::REG_FRAME_ROOM, pick_room());
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 35);
      repeat (n) push_byte(pick_byte(), $urandom_range(0, 5) == 0);
      drain();
    end

    $display("sent %0d payload bytes through %0d register writes", n_items, n_writes);
    $display("rooms from below minimum to 65535, escapes and mid-frame changes");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
